[design/dpm_pkg.sv]
// Shared types, constants and helper functions for the dew point pipeline.
package dpm_pkg;

	// Field widths of the two channels
	localparam int T_W  = 15;
	localparam int H_W  = 14;
	localparam int DP_W = 15;
	localparam int ST_W = 2;

	// Status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_ZERO  = 2'd1;
	localparam logic [ST_W-1:0] ST_CLAMP = 2'd2;

	// Magnus coefficients: a in 0.001, b in 0.01 degC, b*1000 for the final numerator
	localparam logic [14:0] A_LOW   = 15'd17966;
	localparam logic [14:0] A_HIGH  = 15'd17368;
	localparam logic [14:0] B_LOW   = 15'd24715;
	localparam logic [14:0] B_HIGH  = 15'd23888;
	localparam logic [24:0] BK_LOW  = 25'd24715000;
	localparam logic [24:0] BK_HIGH = 25'd23888000;
	localparam logic signed [10:0] K1000 = 11'sd1000;

	localparam logic [H_W-1:0] RH_FULL = 14'd10000;
	localparam logic signed [DP_W-1:0] DP_MIN = -15'sd12000;
	localparam logic signed [DP_W-1:0] DP_MAX = 15'sd8500;

	// log2 unit: Q.30 result, 4 integer bits for a 14-bit argument
	localparam int LOG_FRAC = 30;
	localparam int LOG_W    = LOG_FRAC + 4;
	localparam int LN2_W    = 30;
	localparam logic [LN2_W-1:0] LN2_Q30 = 30'd744261118;

	// Elaboration-time log2 in Q.30, same squaring recurrence as the pipeline
	function automatic logic [LOG_W-1:0] log2_q30_c(input logic [H_W-1:0] v);
		logic [63:0] m;
		logic [LOG_W-1:0] r;
		int e;
		e = 0;
		for (int k = 0; k < H_W; k++) begin
			if (v[k]) e = k;
		end
		m = 64'(v) << (LOG_FRAC - e);
		r = LOG_W'(e) << LOG_FRAC;
		for (int i = 0; i < LOG_FRAC; i++) begin
			m = (m * m) >> LOG_FRAC;
			if (m >= (64'd2 << LOG_FRAC)) begin
				m = m >> 1;
				r[LOG_FRAC-1-i] = 1'b1;
			end
		end
		return r;
	endfunction

	localparam logic [LOG_W-1:0] LOG_FULL = log2_q30_c(RH_FULL);

	// Sideband carried along the two long pipelines
	typedef struct packed {
		logic            zero;
		logic [ST_W-1:0] stat;
		logic            neg;
	} side1_t;

	typedef struct packed {
		logic            zero;
		logic [ST_W-1:0] stat;
		logic            neg;
		logic            bad;
	} side2_t;

endpackage

[design/dpm_if.sv]
// Valid/ready channel interfaces for samples in and dew points out.
interface dpm_in_if;
	import dpm_pkg::*;
	logic                  valid;
	logic                  ready;
	logic signed [T_W-1:0] temperature;
	logic [H_W-1:0]        humidity;
	modport source (output valid, output temperature, output humidity, input ready);
	modport sink (input valid, input temperature, input humidity, output ready);
endinterface

interface dpm_out_if;
	import dpm_pkg::*;
	logic                   valid;
	logic                   ready;
	logic signed [DP_W-1:0] dewpt;
	logic [ST_W-1:0]        status;
	modport source (output valid, output dewpt, output status, input ready);
	modport sink (input valid, input dewpt, input status, output ready);
endinterface

[design/dpm_log2.sv]
// Pipelined log2 in Q.30: one squaring step per stage, padded to DEPTH stages.
module dpm_log2 #(
	parameter int DEPTH = 30
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [dpm_pkg::LOG_FRAC:0]    mant,
	input  logic [3:0]                    expo,
	output logic [dpm_pkg::LOG_W-1:0]     lg
);
	import dpm_pkg::*;

	logic [LOG_FRAC:0]  m_s [DEPTH];
	logic [LOG_W-1:0]   r_s [DEPTH];

	for (genvar k = 0; k < DEPTH; k++) begin : g_st
		logic [LOG_FRAC:0] m_in;
		logic [LOG_W-1:0]  r_in;
		logic [LOG_FRAC:0] m_nx;
		logic [LOG_W-1:0]  r_nx;

		if (k == 0) begin : g_first
			assign m_in = mant;
			assign r_in = {expo, {LOG_FRAC{1'b0}}};
		end else begin : g_next
			assign m_in = m_s[k-1];
			assign r_in = r_s[k-1];
		end

		if (k < LOG_FRAC) begin : g_sq
			// square the mantissa; renormalize and emit one fraction bit
			logic [2*LOG_FRAC+1:0] sq;
			logic [LOG_FRAC+1:0]   hi;
			assign sq   = (2*LOG_FRAC+2)'(m_in) * (2*LOG_FRAC+2)'(m_in);
			assign hi   = sq[2*LOG_FRAC+1:LOG_FRAC];
			assign m_nx = hi[LOG_FRAC+1] ? hi[LOG_FRAC+1:1] : hi[LOG_FRAC:0];
			assign r_nx = r_in | (LOG_W'(hi[LOG_FRAC+1]) << (LOG_FRAC - 1 - k));
		end else begin : g_pad
			assign m_nx = m_in;
			assign r_nx = r_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m_s[k] <= m_nx;
				r_s[k] <= r_nx;
			end
		end
	end

	assign lg = r_s[DEPTH-1];

endmodule

[design/dpm_div.sv]
// Pipelined restoring divider: one quotient bit per stage, sideband travels along.
module dpm_div #(
	parameter int DW = 26,
	parameter int QW = 30,
	parameter int SW = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_v,
	input  logic [SW-1:0]      in_side,
	input  logic [DW+QW-1:0]   num,
	input  logic [DW-1:0]      den,
	output logic               out_v,
	output logic [SW-1:0]      out_side,
	output logic [QW-1:0]      quo
);
	localparam int RW = DW + QW;

	logic            vld_s  [QW];
	logic [SW-1:0]   side_s [QW];
	logic [RW-1:0]   rem_s  [QW];
	logic [DW-1:0]   den_s  [QW];
	logic [QW-1:0]   quo_s  [QW];

	for (genvar k = 0; k < QW; k++) begin : g_st
		logic          v_in;
		logic [SW-1:0] sd_in;
		logic [RW-1:0] rem_in;
		logic [DW-1:0] den_in;
		logic [QW-1:0] q_in;
		logic [RW:0]   diff;
		logic          ge;

		if (k == 0) begin : g_first
			assign v_in   = in_v;
			assign sd_in  = in_side;
			assign rem_in = num;
			assign den_in = den;
			assign q_in   = '0;
		end else begin : g_next
			assign v_in   = vld_s[k-1];
			assign sd_in  = side_s[k-1];
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign q_in   = quo_s[k-1];
		end

		// trial subtract of the divisor aligned to this quotient bit
		assign diff = {1'b0, rem_in} - ((RW+1)'(den_in) << (QW - 1 - k));
		assign ge   = ~diff[RW];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= sd_in;
				den_s[k]  <= den_in;
				rem_s[k]  <= ge ? diff[RW-1:0] : rem_in;
				quo_s[k]  <= q_in | (QW'(ge) << (QW - 1 - k));
			end
		end
	end

	assign out_v    = vld_s[QW-1];
	assign out_side = side_s[QW-1];
	assign quo      = quo_s[QW-1];

endmodule

[design/dew_point_magnus.sv]
// Dew point by the Magnus formula: pipelined fixed-point datapath, top level.
// Channels: sample (sink) carries temperature (signed, 0.01 degC) and humidity
// (0.01 %); result (source) carries dewpt (signed, 0.01 degC) and status.
// A transfer happens on a rising edge with valid and ready both high.
// Every sample gives exactly one result, in order.
// The path from sample transfer to result valid is set by the 30-step log2
// squaring pipeline (or the term divider when it needs more quotient bits),
// plus the 16-bit rounding divider and the multiply stages around them.
// Throughput: one sample per cycle with the result side taking every cycle.
// Stall: an output skid register catches the result while the receiver holds
// ready low; sample.ready then drops and the whole pipeline freezes until the
// skid register drains. Nothing is lost or repeated.
// Humidity zero gives -12000 with status 1; humidity above 100 % is clamped
// with status 2; the result saturates to -12000..8500.
// Reset (arst_n low) clears the valid flags of the pipeline and the skid register;
// the data registers are not reset, and no sweep is needed after reset.
module dew_point_magnus #(
	parameter int FRAC_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	dpm_in_if.sink    sample,
	dpm_out_if.source result
);
	import dpm_pkg::*;

	localparam int QB   = (FRAC_BITS + 7 > LOG_FRAC) ? FRAC_BITS + 7 : LOG_FRAC;
	localparam int D1W  = 26;
	localparam int AW   = FRAC_BITS + 8;
	localparam int LNW  = FRAC_BITS + 5;
	localparam int SPL  = 17;
	localparam int PW   = LOG_W - SPL + LN2_W;
	localparam int SUMW = LOG_W + LN2_W + 1;
	localparam int N2W  = 26 + AW;
	localparam int D2SW = AW + 12;
	localparam int D2W  = FRAC_BITS + 16;
	localparam int Q2W  = 16;
	localparam int R2W  = D2W + Q2W;
	localparam int S1W  = $bits(side1_t);
	localparam int S2W  = $bits(side2_t);
	localparam logic signed [16:0] LIM_LO = 17'(DP_MIN);
	localparam logic signed [16:0] LIM_HI = 17'(DP_MAX);

	logic en;
	logic skid_q;

	assign en           = ~skid_q;
	assign sample.ready = en;

	// ---------------- stage 1: classify, clamp, select coefficients
	logic            v_s1;
	side1_t          sd_s1;
	logic [14:0]     abst_s1;
	logic [14:0]     a_s1;
	logic [15:0]     bsum_s1;
	logic [H_W-1:0]  hc_s1;

	logic            zero_w, clamp_w, neg_w;
	logic [14:0]     b_w;
	logic signed [16:0] bsum_w;

	always_comb begin
		zero_w  = (sample.humidity == '0);
		clamp_w = (sample.humidity > RH_FULL);
		neg_w   = sample.temperature[T_W-1];
		b_w     = neg_w ? B_LOW : B_HIGH;
		bsum_w  = $signed({2'b00, b_w}) + 17'(sample.temperature);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s1.zero <= zero_w;
			sd_s1.stat <= clamp_w ? ST_CLAMP : ST_OK;
			sd_s1.neg  <= neg_w;
			abst_s1    <= neg_w ? 15'(-sample.temperature) : 15'(sample.temperature);
			a_s1       <= neg_w ? A_LOW : A_HIGH;
			bsum_s1    <= bsum_w[15:0];
			hc_s1      <= clamp_w ? RH_FULL : sample.humidity;
		end
	end

	// ---------------- stage 2: a*|T|, 1000*(b+T), normalize humidity for log2
	logic             v_s2;
	side1_t           sd_s2;
	logic [29:0]      prod_s2;
	logic [D1W-1:0]   den1_s2;
	logic [LOG_FRAC:0] mant_s2;
	logic [3:0]       expo_s2;
	logic [3:0]       expo_w;

	always_comb begin
		expo_w = '0;
		for (int k = 0; k < H_W; k++) begin
			if (hc_s1[k]) expo_w = 4'(k);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s2   <= sd_s1;
			prod_s2 <= 30'(a_s1) * 30'(abst_s1);
			den1_s2 <= D1W'(bsum_s1) * D1W'(10'd1000);
			mant_s2 <= (LOG_FRAC+1)'(hc_s1) << (LOG_FRAC - 32'(expo_w));
			expo_s2 <= expo_w;
		end
	end

	// ---------------- term divider and log2 unit run side by side
	logic            v_dv1;
	logic [S1W-1:0]  sd_dv1_w;
	side1_t          sd_dv1;
	logic [QB-1:0]   q1;
	logic [LOG_W-1:0] lgh;

	dpm_div #(.DW(D1W), .QW(QB), .SW(S1W)) u_div_term (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s2),
		.in_side  (sd_s2),
		.num      ((D1W+QB)'({prod_s2, {FRAC_BITS{1'b0}}})),
		.den      (den1_s2),
		.out_v    (v_dv1),
		.out_side (sd_dv1_w),
		.quo      (q1)
	);

	assign sd_dv1 = side1_t'(sd_dv1_w);

	dpm_log2 #(.DEPTH(QB)) u_log2 (
		.clk  (clk),
		.en   (en),
		.mant (mant_s2),
		.expo (expo_s2),
		.lg   (lgh)
	);

	// ---------------- stage 3: signed term, log magnitude
	logic                 v_s3;
	side1_t               sd_s3;
	logic signed [AW-1:0] term_s3;
	logic [LOG_W-1:0]     mag_s3;
	logic signed [AW-1:0] q1_w;

	assign q1_w = $signed(AW'(q1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_dv1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s3   <= sd_dv1;
			term_s3 <= sd_dv1.neg ? -q1_w : q1_w;
			mag_s3  <= LOG_FULL - lgh;
		end
	end

	// ---------------- stage 4: magnitude times ln2, as two partial products
	logic                 v_s4;
	side1_t               sd_s4;
	logic signed [AW-1:0] term_s4;
	logic [PW-1:0]        ph_s4;
	logic [SPL+LN2_W-1:0] pl_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s4   <= sd_s3;
			term_s4 <= term_s3;
			ph_s4   <= PW'(mag_s3[LOG_W-1:SPL]) * PW'(LN2_Q30);
			pl_s4   <= (SPL+LN2_W)'(mag_s3[SPL-1:0]) * (SPL+LN2_W)'(LN2_Q30);
		end
	end

	// ---------------- stage 5: combine partial products, scale to Q.FRAC_BITS
	logic                 v_s5;
	side1_t               sd_s5;
	logic signed [AW-1:0] term_s5;
	logic [LNW-1:0]       ln_s5;
	logic [SUMW-1:0]      psum_w;

	assign psum_w = SUMW'({ph_s4, {SPL{1'b0}}}) + SUMW'(pl_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s5   <= sd_s4;
			term_s5 <= term_s4;
			ln_s5   <= psum_w[2*LOG_FRAC-FRAC_BITS +: LNW];
		end
	end

	// ---------------- stage 6: alpha = term + ln(RH/100)
	logic                 v_s6;
	side1_t               sd_s6;
	logic signed [AW-1:0] alpha_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s6    <= sd_s5;
			alpha_s6 <= term_s5 - $signed(AW'(ln_s5));
		end
	end

	// ---------------- stage 7: numerator b*1000*alpha, denominator a - alpha
	logic                   v_s7;
	side1_t                 sd_s7;
	logic signed [N2W-1:0]  num2_s7;
	logic signed [D2SW-1:0] den2_s7;
	logic [24:0]            bk_w;
	logic [14:0]            ak_w;

	assign bk_w = sd_s6.neg ? BK_LOW : BK_HIGH;
	assign ak_w = sd_s6.neg ? A_LOW : A_HIGH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s7   <= sd_s6;
			num2_s7 <= $signed({1'b0, bk_w}) * alpha_s6;
			den2_s7 <= $signed(D2SW'({ak_w, {FRAC_BITS{1'b0}}})) - K1000 * alpha_s6;
		end
	end

	// ---------------- stage 8: magnitudes and half-divisor bias for rounding
	logic            v_s8;
	side2_t          sd_s8;
	logic [R2W-1:0]  nmag_s8;
	logic [D2W-1:0]  dmag_s8;
	logic [N2W-1:0]  absn_w;
	logic [D2W-1:0]  dmag_w;
	logic            bad_w;

	always_comb begin
		absn_w = num2_s7[N2W-1] ? N2W'(-num2_s7) : N2W'(num2_s7);
		bad_w  = den2_s7[D2SW-1] || (den2_s7 == '0);
		dmag_w = den2_s7[D2W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s8.zero <= sd_s7.zero;
			sd_s8.stat <= sd_s7.stat;
			sd_s8.neg  <= num2_s7[N2W-1];
			sd_s8.bad  <= bad_w;
			nmag_s8    <= R2W'(absn_w) + R2W'(dmag_w >> 1);
			dmag_s8    <= bad_w ? D2W'(1) : dmag_w;
		end
	end

	// ---------------- rounding divider
	logic            v_dv2;
	logic [S2W-1:0]  sd_dv2_w;
	side2_t          sd_dv2;
	logic [Q2W-1:0]  q2;

	dpm_div #(.DW(D2W), .QW(Q2W), .SW(S2W)) u_div_dew (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s8),
		.in_side  (sd_s8),
		.num      (nmag_s8),
		.den      (dmag_s8),
		.out_v    (v_dv2),
		.out_side (sd_dv2_w),
		.quo      (q2)
	);

	assign sd_dv2 = side2_t'(sd_dv2_w);

	// ---------------- stage 9: sign, saturation, special cases
	logic                   v_s9;
	logic signed [DP_W-1:0] dp_s9;
	logic [ST_W-1:0]        st_s9;
	logic signed [16:0]     qs_w;
	logic signed [DP_W-1:0] dp_w;

	always_comb begin
		qs_w = sd_dv2.neg ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
		if (sd_dv2.zero) begin
			dp_w = DP_MIN;
		end else if (sd_dv2.bad) begin
			dp_w = DP_MAX;
		end else if (qs_w < LIM_LO) begin
			dp_w = DP_MIN;
		end else if (qs_w > LIM_HI) begin
			dp_w = DP_MAX;
		end else begin
			dp_w = qs_w[DP_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_dv2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dp_s9 <= dp_w;
			st_s9 <= sd_dv2.zero ? ST_ZERO : sd_dv2.stat;
		end
	end

	// ---------------- output skid register
	logic signed [DP_W-1:0] skid_dp_q;
	logic [ST_W-1:0]        skid_st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_q <= 1'b0;
		end else if (skid_q) begin
			if (result.ready) skid_q <= 1'b0;
		end else if (v_s9 && !result.ready) begin
			skid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_q) begin
			skid_dp_q <= dp_s9;
			skid_st_q <= st_s9;
		end
	end

	assign result.valid  = skid_q | v_s9;
	assign result.dewpt  = skid_q ? skid_dp_q : dp_s9;
	assign result.status = skid_q ? skid_st_q : st_s9;

`ifndef SYNTHESIS
	// a stalled skid entry stays put
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_q && !result.ready |=> skid_q && $stable(skid_dp_q) && $stable(skid_st_q))
		else $error("skid register changed under stall");

	// zero humidity always reports the minimum
	a_zero_min: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status == ST_ZERO |-> result.dewpt == DP_MIN)
		else $error("zero humidity without minimum dew point");

	// legal status codes only
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.status == ST_OK || result.status == ST_ZERO ||
			result.status == ST_CLAMP))
		else $error("illegal status code");

	// saturation keeps the dew point in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.dewpt >= DP_MIN && result.dewpt <= DP_MAX))
		else $error("dew point out of range");
`endif

endmodule
